/* design/ahfb_pkg.sv */
// ----------------------------------------------------------------------------
// ahfb_pkg
// Shared types, constants and helpers of the ascii hex frame builder.
// ----------------------------------------------------------------------------
package ahfb_pkg;

    // default build options
    localparam int HEADER_LEN_DEF  = 2;
    localparam int TRAILER_LEN_DEF = 2;
    localparam int MAX_PAYLOAD_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF = 4;

    // fixed framing constants
    localparam logic [15:0] OUTER_EXTRA = 16'd14;
    localparam logic [3:0]  HEX_LAST    = 4'd15;
    localparam logic [3:0]  SUM_LAST    = 4'd1;
    localparam int          REG_W       = 64;
    localparam int          CFG_IDX_W   = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILER = 1'b1;

    // configuration write transaction
    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [REG_W-1:0]     data;
    } t_cfg_wr;

    // classified work for the byte sequencer
    typedef struct packed {
        logic        err;
        logic        start;
        logic        data;
        logic        fin;
        logic [63:0] hex_word;   // outer length, type, length, total, sequence
        logic [7:0]  data_byte;
        logic [7:0]  chk;
    } t_cmd;

    // sequencer phases
    typedef enum logic [2:0] {
        PH_HDR,
        PH_HEX,
        PH_DATA,
        PH_SUM,
        PH_TRL,
        PH_ERR
    } t_phase;

    // lowercase ascii hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h61 + {4'd0, nib} - 8'd10;
        end
        return c;
    endfunction

endpackage

/* design/ascii_hex_frame_builder.sv */
// ----------------------------------------------------------------------------
// ascii_hex_frame_builder
// Frames a byte stream as ascii hex headers, payload, checksum and tail.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_push / o_full): one transaction per item. A start item
//   opens a frame, data items carry payload bytes, a finish item closes it.
//   Result channel (o_empty / i_pop): one transaction per emitted byte, with
//   o_run_last on the last byte an item causes and o_frame_end on the final
//   tail byte. An oversized start yields a single o_length_error result.
//   Configuration: i_cfg_we / i_cfg_idx / i_cfg_data write the header and
//   tail byte registers; write only while the block is idle.
// Timing
//   With the block idle, the first byte of an item passes through the command
//   queue and then the result register on its way to the result ports. The
//   byte sequencer emits one byte per cycle while the receiver pops; an item
//   causes 1 byte for a payload byte, HEADER_LEN + 16 for a start and 2 +
//   TRAILER_LEN for a finish. Input items are taken one per cycle while the
//   four-entry command queue has room.
// Reset and stall
//   Reset empties the queue and the result register, closes any frame and
//   clears both byte registers. When the receiver stalls the result is held,
//   the sequencer waits and o_full rises once the queue fills.
// ----------------------------------------------------------------------------
module ascii_hex_frame_builder #(
    parameter int HEADER_LEN  = ahfb_pkg::HEADER_LEN_DEF,
    parameter int TRAILER_LEN = ahfb_pkg::TRAILER_LEN_DEF,
    parameter int MAX_PAYLOAD = ahfb_pkg::MAX_PAYLOAD_DEF,
    parameter int QUEUE_DEPTH = ahfb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ahfb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ahfb_pkg::REG_W-1:0]     i_cfg_data,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic                           i_start_req,
    input  logic                           i_has_data,
    input  logic                           i_finish,
    input  logic [15:0]                    i_type_id,
    input  logic [15:0]                    i_payload_len,
    input  logic [7:0]                     i_pkg_total,
    input  logic [7:0]                     i_pkg_seq,
    input  logic [7:0]                     i_data_byte,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [7:0]                     o_out_byte,
    output logic                           o_run_last,
    output logic                           o_frame_end,
    output logic                           o_length_error
);
    import ahfb_pkg::*;

    t_cfg_wr cfg;
    t_cmd    front_cmd;
    t_cmd    head_cmd;
    logic    accept;
    logic    cmd_push;
    logic    cmd_pop;
    logic    cmd_valid;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;
    assign accept   = i_push && !o_full;

    // item classification
    ahfb_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_start_req   (i_start_req),
        .i_has_data    (i_has_data),
        .i_finish      (i_finish),
        .i_type_id     (i_type_id),
        .i_payload_len (i_payload_len),
        .i_pkg_total   (i_pkg_total),
        .i_pkg_seq     (i_pkg_seq),
        .i_data_byte   (i_data_byte),
        .o_cmd_push    (cmd_push),
        .o_cmd         (front_cmd)
    );

    // command queue
    ahfb_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (front_cmd),
        .o_full  (o_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (head_cmd)
    );

    // byte sequencer and result register
    ahfb_back #(
        .HEADER_LEN  (HEADER_LEN),
        .TRAILER_LEN (TRAILER_LEN)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (head_cmd),
        .o_cmd_pop      (cmd_pop),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last),
        .o_frame_end    (o_frame_end),
        .o_length_error (o_length_error)
    );

endmodule

/* design/ahfb_front.sv */
// ----------------------------------------------------------------------------
// ahfb_front
// Accepts input items, tracks the open frame and the running checksum, and
// turns each item that yields output into one command for the sequencer.
// ----------------------------------------------------------------------------
module ahfb_front #(
    parameter int MAX_PAYLOAD = ahfb_pkg::MAX_PAYLOAD_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_start_req,
    input  logic          i_has_data,
    input  logic          i_finish,
    input  logic [15:0]   i_type_id,
    input  logic [15:0]   i_payload_len,
    input  logic [7:0]    i_pkg_total,
    input  logic [7:0]    i_pkg_seq,
    input  logic [7:0]    i_data_byte,
    output logic          o_cmd_push,
    output ahfb_pkg::t_cmd o_cmd
);
    import ahfb_pkg::*;

    logic       r_in_frame;
    logic       n_in_frame;
    logic [7:0] r_xor;
    logic [7:0] n_xor;
    logic [7:0] start_xor;

    // checksum over the twelve summed header characters
    always_comb begin
        logic [47:0] fields;
        logic [7:0]  acc;
        fields = {i_type_id, i_payload_len, i_pkg_total, i_pkg_seq};
        acc    = 8'd0;
        for (int k = 0; k < 12; k++) begin
            acc = acc ^ hex_char(fields[4*k +: 4]);
        end
        start_xor = acc;
    end

    // classification and next frame state
    always_comb begin
        logic       frame;
        logic [7:0] sum;
        logic       err;
        frame = r_in_frame;
        sum   = r_xor;
        err   = i_start_req && (i_payload_len > 16'(MAX_PAYLOAD));

        o_cmd.err       = err;
        o_cmd.start     = 1'b0;
        o_cmd.data      = 1'b0;
        o_cmd.fin       = 1'b0;
        o_cmd.hex_word  = {i_payload_len + OUTER_EXTRA, i_type_id, i_payload_len,
                           i_pkg_total, i_pkg_seq};
        o_cmd.data_byte = i_data_byte;
        o_cmd.chk       = 8'd0;

        if (err) begin
            frame = 1'b0;
            sum   = 8'd0;
        end else begin
            if (i_start_req) begin
                frame       = 1'b1;
                sum         = start_xor;
                o_cmd.start = 1'b1;
            end
            if (i_has_data && frame) begin
                sum        = sum ^ i_data_byte;
                o_cmd.data = 1'b1;
            end
            if (i_finish && frame) begin
                o_cmd.fin = 1'b1;
                o_cmd.chk = sum;
                frame     = 1'b0;
                sum       = 8'd0;
            end
        end

        n_in_frame = frame;
        n_xor      = sum;
        o_cmd_push = i_accept && (o_cmd.err || o_cmd.start || o_cmd.data || o_cmd.fin);
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_xor      <= 8'd0;
        end else if (i_accept) begin
            r_in_frame <= n_in_frame;
            r_xor      <= n_xor;
        end
    end

endmodule

/* design/ahfb_cmd_queue.sv */
// ----------------------------------------------------------------------------
// ahfb_cmd_queue
// Short command queue between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module ahfb_cmd_queue #(
    parameter int DEPTH = ahfb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ahfb_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ahfb_pkg::t_cmd o_cmd
);
    import ahfb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* design/ahfb_back.sv */
// ----------------------------------------------------------------------------
// ahfb_back
// Byte sequencer: walks each command through its header, hex, payload,
// checksum and tail phases, or its error phase, and drives the registered result port.
// ----------------------------------------------------------------------------
module ahfb_back #(
    parameter int HEADER_LEN  = ahfb_pkg::HEADER_LEN_DEF,
    parameter int TRAILER_LEN = ahfb_pkg::TRAILER_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ahfb_pkg::t_cfg_wr i_cfg,
    input  logic              i_cmd_valid,
    input  ahfb_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [7:0]        o_out_byte,
    output logic              o_run_last,
    output logic              o_frame_end,
    output logic              o_length_error
);
    import ahfb_pkg::*;

    localparam int         HDR_TOP  = HEADER_LEN - 1;
    localparam int         TRL_TOP  = TRAILER_LEN - 1;
    localparam logic [3:0] HDR_LAST = 4'(HDR_TOP);
    localparam logic [3:0] TRL_LAST = 4'(TRL_TOP);

    logic [REG_W-1:0] r_header;
    logic [REG_W-1:0] r_trailer;

    logic   r_active;
    logic   n_active;
    t_phase r_phase;
    t_phase n_phase;
    logic [3:0] r_idx;
    logic [3:0] n_idx;

    t_phase     cur_phase;
    logic [3:0] cur_idx;
    logic       out_ready;
    logic       emit;
    logic       cmd_done;

    logic [7:0] byte_val;
    logic       byte_end;
    logic       byte_err;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_end;
    logic       r_out_err;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= '0;
            r_trailer <= '0;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                CFG_HEADER:  r_header  <= i_cfg.data;
                CFG_TRAILER: r_trailer <= i_cfg.data;
                default:     ;
            endcase
        end
    end

    // current position within the head command
    always_comb begin
        t_phase first;
        priority if (i_cmd.err) begin
            first = PH_ERR;
        end else if (i_cmd.start) begin
            first = PH_HDR;
        end else if (i_cmd.data) begin
            first = PH_DATA;
        end else begin
            first = PH_SUM;
        end
        cur_phase = r_active ? r_phase : first;
        cur_idx   = r_active ? r_idx : 4'd0;
    end

    assign out_ready = !r_out_valid || i_pop;
    assign emit      = i_cmd_valid && out_ready;
    assign o_cmd_pop = emit && cmd_done;

    // next phase
    always_comb begin
        n_phase  = cur_phase;
        n_idx    = cur_idx + 4'd1;
        cmd_done = 1'b0;
        unique case (cur_phase)
            PH_HDR: begin
                if (cur_idx == HDR_LAST) begin
                    n_phase = PH_HEX;
                    n_idx   = 4'd0;
                end
            end
            PH_HEX: begin
                if (cur_idx == HEX_LAST) begin
                    n_idx = 4'd0;
                    priority if (i_cmd.data) begin
                        n_phase = PH_DATA;
                    end else if (i_cmd.fin) begin
                        n_phase = PH_SUM;
                    end else begin
                        cmd_done = 1'b1;
                    end
                end
            end
            PH_DATA: begin
                n_idx = 4'd0;
                if (i_cmd.fin) begin
                    n_phase = PH_SUM;
                end else begin
                    cmd_done = 1'b1;
                end
            end
            PH_SUM: begin
                if (cur_idx == SUM_LAST) begin
                    n_phase = PH_TRL;
                    n_idx   = 4'd0;
                end
            end
            PH_TRL: begin
                if (cur_idx == TRL_LAST) begin
                    cmd_done = 1'b1;
                end
            end
            PH_ERR: begin
                cmd_done = 1'b1;
            end
            default: begin
                cmd_done = 1'b1;
            end
        endcase
        n_active = !cmd_done;
    end

    // byte for the current position
    always_comb begin
        logic [5:0]       hdr_sh;
        logic [5:0]       trl_sh;
        logic [5:0]       hex_sh;
        logic [REG_W-1:0] hdr_sel;
        logic [REG_W-1:0] trl_sel;
        logic [63:0]      hex_sel;
        hdr_sh   = 6'(8 * (HDR_TOP - int'(cur_idx)));
        trl_sh   = 6'(8 * (TRL_TOP - int'(cur_idx)));
        hex_sh   = {~cur_idx, 2'b00};
        hdr_sel  = r_header >> hdr_sh;
        trl_sel  = r_trailer >> trl_sh;
        hex_sel  = i_cmd.hex_word >> hex_sh;
        byte_end = 1'b0;
        byte_err = 1'b0;
        unique case (cur_phase)
            PH_HDR:  byte_val = hdr_sel[7:0];
            PH_HEX:  byte_val = hex_char(hex_sel[3:0]);
            PH_DATA: byte_val = i_cmd.data_byte;
            PH_SUM:  byte_val = hex_char(cur_idx[0] ? i_cmd.chk[3:0] : i_cmd.chk[7:4]);
            PH_TRL: begin
                byte_val = trl_sel[7:0];
                byte_end = (cur_idx == TRL_LAST);
            end
            PH_ERR: begin
                byte_val = 8'd0;
                byte_err = 1'b1;
            end
            default: byte_val = 8'd0;
        endcase
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_phase  <= PH_HDR;
            r_idx    <= 4'd0;
        end else if (emit) begin
            r_active <= n_active;
            r_phase  <= n_phase;
            r_idx    <= n_idx;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= i_cmd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= byte_val;
            r_out_last <= cmd_done;
            r_out_end  <= byte_end;
            r_out_err  <= byte_err;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_run_last     = r_out_last;
    assign o_frame_end    = r_out_end;
    assign o_length_error = r_out_err;

endmodule

/* tb/sv/ascii_hex_frame_builder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascii_hex_frame_builder_tb
// Self-checking bench for the ascii hex frame builder. Items are pushed
// through the input queue and every framed byte is popped and compared with a
// scoreboard that rebuilds header, hex fields, payload, checksum and tail.
// Directed corner items come first, then random frames under several header
// and tail settings, mostly with random idling on both sides.
// ----------------------------------------------------------------------------
module ascii_hex_frame_builder_tb;

    import ahfb_pkg::*;

    localparam int  CLK_HALF    = 4;
    localparam int  SETTLE      = 40;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  ITEMS_GOAL  = 370;

    // one input transaction
    typedef struct packed {
        logic        start_req;
        logic        has_data;
        logic        finish;
        logic [15:0] type_id;
        logic [15:0] payload_len;
        logic [7:0]  pkg_total;
        logic [7:0]  pkg_seq;
        logic [7:0]  data_byte;
    } t_frame_item;

    // one framed output byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
        logic       length_error;
    } t_frame_byte;

    // framed byte scoreboard
    class frame_scoreboard;
        logic [REG_W-1:0] header_reg;
        logic [REG_W-1:0] trailer_reg;
        logic             open_frame;
        logic [7:0]       running_xor;
        t_frame_byte      expected_bytes[$];
        int               mismatches;
        string            hex_digits;

        function new();
            header_reg  = '0;
            trailer_reg = '0;
            open_frame  = 1'b0;
            running_xor = 8'h00;
            mismatches  = 0;
            hex_digits  = "0123456789abcdef";
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
            if (idx == CFG_HEADER) begin
                header_reg = val;
            end else if (idx == CFG_TRAILER) begin
                trailer_reg = val;
            end
        endfunction

        function void add_byte(logic [7:0] b, logic fend, logic err);
            t_frame_byte r;
            r.out_byte     = b;
            r.run_last     = 1'b0;
            r.frame_end    = fend;
            r.length_error = err;
            expected_bytes.push_back(r);
        endfunction

        // lowercase hex characters, high nibble first
        function void add_hex(logic [15:0] v, int digits, bit summed);
            logic [7:0] c;
            for (int i = digits - 1; i >= 0; i--) begin
                c = hex_digits[v[4*i +: 4]];
                if (summed) begin
                    running_xor ^= c;
                end
                add_byte(c, 1'b0, 1'b0);
            end
        endfunction

        // byte idx of a register laid out on len bytes, first byte highest
        function logic [7:0] reg_byte(logic [REG_W-1:0] r, int len, int idx);
            return r[8*(len-1-idx) +: 8];
        endfunction

        // predicts the bytes caused by one accepted item
        function int note_item(t_frame_item it);
            int before_n;
            before_n = expected_bytes.size();
            if (it.start_req) begin
                if (it.payload_len > MAX_PAYLOAD_DEF) begin
                    open_frame  = 1'b0;
                    running_xor = 8'h00;
                    add_byte(8'h00, 1'b0, 1'b1);
                    expected_bytes[expected_bytes.size()-1].run_last = 1'b1;
                    return 1;
                end
                open_frame  = 1'b1;
                running_xor = 8'h00;
                for (int i = 0; i < HEADER_LEN_DEF; i++) begin
                    add_byte(reg_byte(header_reg, HEADER_LEN_DEF, i), 1'b0, 1'b0);
                end
                add_hex(it.payload_len + OUTER_EXTRA, 4, 1'b0);
                add_hex(it.type_id, 4, 1'b1);
                add_hex(it.payload_len, 4, 1'b1);
                add_hex({8'h00, it.pkg_total}, 2, 1'b1);
                add_hex({8'h00, it.pkg_seq}, 2, 1'b1);
            end
            if (it.has_data && open_frame) begin
                running_xor ^= it.data_byte;
                add_byte(it.data_byte, 1'b0, 1'b0);
            end
            if (it.finish && open_frame) begin
                add_hex({8'h00, running_xor}, 2, 1'b0);
                for (int i = 0; i < TRAILER_LEN_DEF; i++) begin
                    add_byte(reg_byte(trailer_reg, TRAILER_LEN_DEF, i),
                             i == TRAILER_LEN_DEF - 1, 1'b0);
                end
                open_frame  = 1'b0;
                running_xor = 8'h00;
            end
            if (expected_bytes.size() > before_n) begin
                expected_bytes[expected_bytes.size()-1].run_last = 1'b1;
            end
            return expected_bytes.size() - before_n;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // one line per mismatch
        task report(string msg);
            mismatches++;
            $display("%0t mismatch: %s", $time, msg);
        endtask

        task check_byte(t_frame_byte got);
            t_frame_byte want;
            if (expected_bytes.size() == 0) begin
                report($sformatf("byte %h with nothing outstanding", got.out_byte));
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                report($sformatf("out_byte want %h got %h", want.out_byte, got.out_byte));
            end
            if (got.run_last !== want.run_last) begin
                report($sformatf("run_last want %b got %b", want.run_last, got.run_last));
            end
            if (got.frame_end !== want.frame_end) begin
                report($sformatf("frame_end want %b got %b", want.frame_end,
                                 got.frame_end));
            end
            if (got.length_error !== want.length_error) begin
                report($sformatf("length_error want %b got %b", want.length_error,
                                 got.length_error));
            end
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [REG_W-1:0]     i_cfg_data;
    logic                 i_push;
    logic                 o_full;
    logic                 i_start_req;
    logic                 i_has_data;
    logic                 i_finish;
    logic [15:0]          i_type_id;
    logic [15:0]          i_payload_len;
    logic [7:0]           i_pkg_total;
    logic [7:0]           i_pkg_seq;
    logic [7:0]           i_data_byte;
    logic                 o_empty;
    logic                 i_pop;
    logic [7:0]           o_out_byte;
    logic                 o_run_last;
    logic                 o_frame_end;
    logic                 o_length_error;

    frame_scoreboard sb;
    int              busy_items;
    int              send_idle_pct;
    int              pop_idle_pct;
    int              pop_stall_left;

    ascii_hex_frame_builder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_start_req    (i_start_req),
        .i_has_data     (i_has_data),
        .i_finish       (i_finish),
        .i_type_id      (i_type_id),
        .i_payload_len  (i_payload_len),
        .i_pkg_total    (i_pkg_total),
        .i_pkg_seq      (i_pkg_seq),
        .i_data_byte    (i_data_byte),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last),
        .o_frame_end    (o_frame_end),
        .o_length_error (o_length_error)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // watchdog
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // receiver: random stall bursts
    initial begin
        pop_stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (pop_stall_left > 0) begin
                pop_stall_left--;
                i_pop <= 1'b0;
            end else if ($urandom_range(0, 99) < pop_idle_pct) begin
                pop_stall_left = $urandom_range(1, 10) - 1;
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    // result transaction check
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty) begin
            sb.check_byte({o_out_byte, o_run_last, o_frame_end, o_length_error});
        end
    end

    function automatic t_frame_item mk_item(logic s, logic d, logic f, logic [15:0] ty,
                                            logic [15:0] pl, logic [7:0] tot,
                                            logic [7:0] seq, logic [7:0] db);
        t_frame_item it;
        it.start_req   = s;
        it.has_data    = d;
        it.finish      = f;
        it.type_id     = ty;
        it.payload_len = pl;
        it.pkg_total   = tot;
        it.pkg_seq     = seq;
        it.data_byte   = db;
        return it;
    endfunction

    function automatic t_frame_item rand_fields();
        return mk_item(1'b0, 1'b0, 1'b0, 16'($urandom), 16'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom));
    endfunction

    // push one item; entered and left at a falling edge
    task automatic send_item(input t_frame_item it);
        bit taken;
        int made;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_push        <= 1'b1;
        i_start_req   <= it.start_req;
        i_has_data    <= it.has_data;
        i_finish      <= it.finish;
        i_type_id     <= it.type_id;
        i_payload_len <= it.payload_len;
        i_pkg_total   <= it.pkg_total;
        i_pkg_seq     <= it.pkg_seq;
        i_data_byte   <= it.data_byte;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (!o_full) begin
                taken = 1'b1;
                made  = sb.note_item(it);
                if (made > 0) begin
                    busy_items++;
                end
            end
            @(negedge i_clk);
        end
    endtask

    // write both byte registers back to back
    task automatic load_regs(input logic [REG_W-1:0] hdr, input logic [REG_W-1:0] trl);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_HEADER;
        i_cfg_data <= hdr;
        @(posedge i_clk);
        sb.set_reg(CFG_HEADER, hdr);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_TRAILER;
        i_cfg_data <= trl;
        @(posedge i_clk);
        sb.set_reg(CFG_TRAILER, trl);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every expected byte is out, then let the bench settle
    task automatic drain();
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic directed_items();
        send_item(mk_item(1, 0, 0, 16'h0000, 16'd0, 8'h00, 8'h00, 8'h00));
        send_item(mk_item(0, 0, 1, 16'h0000, 16'd0, 8'h00, 8'h00, 8'h00));
        // longest legal payload, data rides on the start
        send_item(mk_item(1, 1, 0, 16'hffff, 16'(MAX_PAYLOAD_DEF), 8'hff, 8'hff, 8'h00));
        send_item(mk_item(0, 1, 0, 16'h0000, 16'd0, 8'h00, 8'h00, 8'hff));
        send_item(mk_item(0, 1, 1, 16'h0000, 16'd0, 8'h00, 8'h00, 8'h5a));
        // whole frame in one item, the most bytes one item can cause
        send_item(mk_item(1, 1, 1, 16'h1234, 16'd3, 8'h9c, 8'h07, 8'he1));
        // data, finish and nothing with no open frame
        send_item(mk_item(0, 1, 0, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff));
        send_item(mk_item(0, 0, 1, 16'h0000, 16'd0, 8'h00, 8'h00, 8'h00));
        send_item(mk_item(0, 0, 0, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff));
        // oversize lengths, flags beside them ignored
        send_item(mk_item(1, 1, 1, 16'habcd, 16'(MAX_PAYLOAD_DEF + 1), 8'h01, 8'h01,
                          8'h33));
        send_item(mk_item(1, 0, 0, 16'h0000, 16'hffff, 8'h00, 8'h00, 8'h00));
        // new start abandons an open frame
        send_item(mk_item(1, 1, 0, 16'h8001, 16'd5, 8'h02, 8'h01, 8'ha5));
        send_item(mk_item(1, 0, 0, 16'habcd, 16'd10, 8'h10, 8'h01, 8'h00));
        send_item(mk_item(0, 1, 0, 16'h0000, 16'd0, 8'h00, 8'h00, 8'h3c));
        // oversize start closes the open frame without tail
        send_item(mk_item(1, 0, 0, 16'h0000, 16'd2000, 8'h00, 8'h00, 8'h00));
        send_item(mk_item(0, 1, 0, 16'h0000, 16'd0, 8'h00, 8'h00, 8'h11));
        send_item(mk_item(0, 0, 1, 16'h0000, 16'd0, 8'h00, 8'h00, 8'h00));
        // payload count differs from the declared length
        send_item(mk_item(1, 0, 0, 16'h00ff, 16'd1, 8'h03, 8'h02, 8'h00));
        send_item(mk_item(0, 1, 0, 16'h0000, 16'd0, 8'h00, 8'h00, 8'h80));
        send_item(mk_item(0, 1, 0, 16'h0000, 16'd0, 8'h00, 8'h00, 8'h7f));
        send_item(mk_item(0, 1, 1, 16'h0000, 16'd0, 8'h00, 8'h00, 8'h01));
        i_push <= 1'b0;
    endtask

    // mostly well formed frames with random content, some noise
    task automatic random_frames(input int want);
        t_frame_item it;
        int          goal;
        int          nbytes;
        bit          closed;
        goal = busy_items + want;
        while (busy_items < goal) begin
            if ($urandom_range(0, 9) < 8) begin
                it = rand_fields();
                it.start_req = 1'b1;
                case ($urandom_range(0, 3))
                    0: it.payload_len = 16'(MAX_PAYLOAD_DEF);
                    1: it.payload_len = 16'($urandom_range(0, MAX_PAYLOAD_DEF));
                    default: it.payload_len = 16'($urandom_range(0, 40));
                endcase
                it.has_data = ($urandom_range(0, 3) == 0);
                send_item(it);
                nbytes = $urandom_range(0, 8);
                closed = 1'b0;
                for (int k = 0; k < nbytes; k++) begin
                    it = rand_fields();
                    it.has_data = 1'b1;
                    if (k == nbytes - 1 && $urandom_range(0, 1) == 1) begin
                        it.finish = 1'b1;
                        closed    = 1'b1;
                    end
                    send_item(it);
                end
                // now and then a frame is left open for the next start
                if (!closed && $urandom_range(0, 7) != 0) begin
                    it = rand_fields();
                    it.finish = 1'b1;
                    send_item(it);
                end
            end else begin
                it = rand_fields();
                {it.start_req, it.has_data, it.finish} = 3'($urandom_range(0, 7));
                send_item(it);
            end
        end
        i_push <= 1'b0;
    endtask

    // main sequence
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_HEADER;
        i_cfg_data    = '0;
        i_push        = 1'b0;
        i_start_req   = 1'b0;
        i_has_data    = 1'b0;
        i_finish      = 1'b0;
        i_type_id     = '0;
        i_payload_len = '0;
        i_pkg_total   = '0;
        i_pkg_seq     = '0;
        i_data_byte   = '0;
        i_pop         = 1'b0;
        busy_items    = 0;
        send_idle_pct = 20;
        pop_idle_pct  = 20;
        sb = new();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        load_regs({$urandom, $urandom}, {$urandom, $urandom});
        directed_items();
        drain();

        // all-zero header, all-one tail, light idling
        load_regs('0, '1);
        send_idle_pct = 15;
        pop_idle_pct  = 15;
        random_frames(ITEMS_GOAL / 4);
        drain();

        // all-one header, all-zero tail, heavy receiver stalls
        load_regs('1, '0);
        send_idle_pct = 5;
        pop_idle_pct  = 40;
        random_frames(ITEMS_GOAL / 4);
        drain();

        // random registers, heavy sender gaps
        load_regs({$urandom, $urandom}, {$urandom, $urandom});
        send_idle_pct = 40;
        pop_idle_pct  = 10;
        random_frames(ITEMS_GOAL / 4);
        drain();

        // random registers, no idling on either side
        load_regs({$urandom, $urandom}, {$urandom, $urandom});
        send_idle_pct = 0;
        pop_idle_pct  = 0;
        random_frames(ITEMS_GOAL / 4);
        drain();

        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
design/ahfb_pkg.sv
design/ahfb_front.sv
design/ahfb_cmd_queue.sv
design/ahfb_back.sv
design/ascii_hex_frame_builder.sv
tb/sv/ascii_hex_frame_builder_tb.sv
